// ===== rtl/rotary_encoder_count_speed_defines.svh =====
// Assertion macros shared by the encoder block.
`ifndef ROTARY_ENCODER_COUNT_SPEED_DEFINES_SVH
`define ROTARY_ENCODER_COUNT_SPEED_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RECS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder block: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RECS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder block: next-cycle check failed");

`endif

// ===== rtl/recs_pkg.sv =====
`default_nettype none

package recs_pkg;

    localparam int TIME_W = 64;
    localparam int CFG_W  = 32;
    localparam int POS_W  = 32;
    localparam int RATE_W = 31;
    localparam int QUO_W  = 30;
    localparam int CNT_W  = 6;

    localparam logic [QUO_W-1:0] NS_PER_SEC     = 30'd1000000000;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 32'd2000000;

    // Status of the serial divider as seen by the sequencer.
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_status_t;

endpackage

`default_nettype wire

// ===== rtl/recs_div.sv =====
`default_nettype none

// Restoring divider: 10^9 / divisor, one quotient bit per cycle.
module recs_div (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [recs_pkg::QUO_W-1:0] divisor,
    output recs_pkg::div_status_t         status
);

    localparam int STEP_W = $clog2(recs_pkg::QUO_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(recs_pkg::QUO_W - 1);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic [recs_pkg::QUO_W-1:0] dsr_reg, dsr_next;
    logic [recs_pkg::QUO_W-1:0] rem_reg, rem_next;
    logic [recs_pkg::QUO_W-1:0] quo_reg, quo_next;

    logic [recs_pkg::QUO_W:0]   rem_sh;
    logic [recs_pkg::QUO_W+1:0] trial;
    logic                       fits;

    always_comb
    begin
        // The dividend bits leave the top of quo_reg as quotient bits enter below.
        rem_sh = {rem_reg, quo_reg[recs_pkg::QUO_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, dsr_reg};
        fits   = !trial[recs_pkg::QUO_W+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = recs_pkg::NS_PER_SEC;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial[recs_pkg::QUO_W-1:0] : rem_sh[recs_pkg::QUO_W-1:0];
            quo_next  = {quo_reg[recs_pkg::QUO_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
            dsr_reg  <= dsr_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
        end
    end

    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/rotary_encoder_count_speed.sv =====
// A counted edge passes the bit-serial time subtract, 30 divider steps and ST_FIN,
// which waits for a free output register, before its result word is registered.
// Gaps of 2^30 ns or more skip the divider; bounced or ignored events end after the
// subtract. A new event is taken only in idle; each passes the 64-bit serial subtractor.
// Reset (rst_n, asynchronous, active low): count and last edge time clear to zero,
// the debounce register returns to 2 ms, no result word pending.
`default_nettype none

`include "rotary_encoder_count_speed_defines.svh"

module rotary_encoder_count_speed (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration: debounce time in nanoseconds.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // Input events.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // event_time_ns[63:0], line_a_level[64],
                                            // line_b_level[65], zero[71:66]
    // Results.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata   // position_out[31:0], signed_rate[62:32],
                                            // zero[63]
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUB,
        ST_DIV,
        ST_FIN
    } state_t;

    localparam logic [recs_pkg::CNT_W-1:0] LAST_BIT = '1;
    localparam logic [recs_pkg::CNT_W-1:0] HI_BIT   = recs_pkg::CNT_W'(recs_pkg::QUO_W);
    localparam logic [recs_pkg::QUO_W-1:0] ONE_MAG  = recs_pkg::QUO_W'(1);

    state_t                          state_reg, state_next;
    logic [recs_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [recs_pkg::CFG_W-1:0]      debounce_reg, debounce_next;
    logic [recs_pkg::TIME_W-1:0]     now_reg, now_next;
    logic [recs_pkg::TIME_W-1:0]     last_reg, last_next;
    logic                            a_reg, a_next;
    logic                            b_reg, b_next;
    logic                            brw_reg, brw_next;
    logic                            cb_reg, cb_next;
    logic                            nz_reg, nz_next;
    logic                            hi_reg, hi_next;
    logic [recs_pkg::QUO_W-1:0]      el_reg, el_next;
    logic [recs_pkg::QUO_W-1:0]      mag_reg, mag_next;
    logic [recs_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                            ovalid_reg, ovalid_next;
    logic [63:0]                     odata_reg, odata_next;

    logic                            in_acc;
    logic                            out_free;
    logic                            load_out;
    logic                            tbit, lbit, dbit, diff;
    logic                            nz_final, hi_final;
    logic                            div_start;
    logic [recs_pkg::QUO_W-1:0]      div_divisor;
    logic [recs_pkg::RATE_W-1:0]     rate_val;
    recs_pkg::div_status_t           div_status;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !ovalid_reg || m_axis_tready;
    assign load_out      = (state_reg == ST_FIN) && out_free;

    // One bit of elapsed = now - last, and of elapsed - debounce, per cycle.
    assign tbit = now_reg[0];
    assign lbit = last_reg[0];
    assign dbit = cnt_reg[recs_pkg::CNT_W-1] ? 1'b0 : debounce_reg[cnt_reg[recs_pkg::CNT_W-2:0]];
    assign diff = tbit ^ lbit ^ brw_reg;

    assign nz_final    = nz_reg | diff;
    assign hi_final    = hi_reg | (diff && (cnt_reg >= HI_BIT));
    assign div_divisor = nz_final ? el_reg : ONE_MAG;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        debounce_next = debounce_reg;
        now_next      = now_reg;
        last_next     = last_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        brw_next      = brw_reg;
        cb_next       = cb_reg;
        nz_next       = nz_reg;
        hi_next       = hi_reg;
        el_next       = el_reg;
        mag_next      = mag_reg;
        pos_next      = pos_reg;
        ovalid_next   = ovalid_reg;
        odata_next    = odata_reg;
        div_start     = 1'b0;
        rate_val      = '0;

        if (cfg_valid && cfg_ready)
        begin
            debounce_next = cfg_data;
        end

        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    now_next   = s_axis_tdata[recs_pkg::TIME_W-1:0];
                    a_next     = s_axis_tdata[64];
                    b_next     = s_axis_tdata[65];
                    cnt_next   = '0;
                    brw_next   = 1'b0;
                    cb_next    = 1'b0;
                    nz_next    = 1'b0;
                    hi_next    = 1'b0;
                    state_next = ST_SUB;
                end
            end

            ST_SUB:
            begin
                // Both time words rotate, so now_reg is whole again at the end of ST_SUB.
                now_next  = {tbit, now_reg[recs_pkg::TIME_W-1:1]};
                last_next = {lbit, last_reg[recs_pkg::TIME_W-1:1]};
                brw_next  = (!tbit && lbit) || (!(tbit ^ lbit) && brw_reg);
                cb_next   = (!diff && dbit) || (!(diff ^ dbit) && cb_reg);
                nz_next   = nz_final;
                hi_next   = hi_final;
                if (cnt_reg < HI_BIT)
                begin
                    el_next = {diff, el_reg[recs_pkg::QUO_W-1:1]};
                end
                cnt_next = cnt_reg + 1'b1;

                if (cnt_reg == LAST_BIT)
                begin
                    if (cb_next)
                    begin
                        // Bounce: keep the time, report nothing.
                        last_next  = {tbit, now_reg[recs_pkg::TIME_W-1:1]};
                        state_next = ST_IDLE;
                    end
                    else if (!a_reg)
                    begin
                        // The final rotation leaves the kept time as it was.
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        last_next = {tbit, now_reg[recs_pkg::TIME_W-1:1]};
                        if (hi_final)
                        begin
                            // A gap of 2^30 ns or more is slower than one step per second.
                            mag_next   = ONE_MAG;
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                end
            end

            ST_DIV:
            begin
                if (div_status.done)
                begin
                    mag_next   = (div_status.quotient == '0) ? ONE_MAG : div_status.quotient;
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    pos_next    = b_reg ? pos_reg + 1'b1 : pos_reg - 1'b1;
                    rate_val    = b_reg ? {1'b0, mag_reg} : -{1'b0, mag_reg};
                    odata_next  = {1'b0, rate_val, pos_next};
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            debounce_reg <= recs_pkg::DEBOUNCE_RESET;
            now_reg      <= '0;
            last_reg     <= '0;
            a_reg        <= 1'b0;
            b_reg        <= 1'b0;
            brw_reg      <= 1'b0;
            cb_reg       <= 1'b0;
            nz_reg       <= 1'b0;
            hi_reg       <= 1'b0;
            el_reg       <= '0;
            mag_reg      <= '0;
            pos_reg      <= '0;
            ovalid_reg   <= 1'b0;
            odata_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            debounce_reg <= debounce_next;
            now_reg      <= now_next;
            last_reg     <= last_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            brw_reg      <= brw_next;
            cb_reg       <= cb_next;
            nz_reg       <= nz_next;
            hi_reg       <= hi_next;
            el_reg       <= el_next;
            mag_reg      <= mag_next;
            pos_reg      <= pos_next;
            ovalid_reg   <= ovalid_next;
            odata_reg    <= odata_next;
        end
    end

    recs_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (div_divisor),
        .status  (div_status)
    );

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    `RECS_ASSERT_NOW(a_rate_nonzero, clk, rst_n, m_axis_tvalid, m_axis_tdata[62:32] != '0)
    `RECS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !s_axis_tready)
    `RECS_ASSERT_NOW(a_div_done_in_div, clk, rst_n, div_status.done, state_reg == ST_DIV)
    `RECS_ASSERT_NEXT(a_pos_only_on_load, clk, rst_n, !load_out, $stable(pos_reg))

endmodule

`default_nettype wire

// ===== tb/tb_rotary_encoder_count_speed.sv =====
module tb_rotary_encoder_count_speed;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES  = 2000;
    localparam int PHASE_EDGES  = 220;

    typedef struct packed {
        logic [recs_pkg::TIME_W-1:0] stamp;
        logic                        line_a;
        logic                        line_b;
    } edge_event_t;

    typedef struct packed {
        logic [recs_pkg::POS_W-1:0]  position;
        logic [recs_pkg::RATE_W-1:0] rate;
    } step_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;  // event_time_ns[63:0], line_a_level[64],
                                     // line_b_level[65], zero[71:66]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;       // position_out[31:0], signed_rate[62:32], zero[63]

    edge_event_t  event_q[$];
    step_result_t step_q[$];
    logic [recs_pkg::CFG_W-1:0] debounce_q[$];

    // Shadow of the block's state, advanced on every accepted word.
    logic [recs_pkg::TIME_W-1:0] kept_time = '0;
    logic [recs_pkg::POS_W-1:0]  detent_count = '0;
    logic [recs_pkg::CFG_W-1:0]  debounce_shadow = recs_pkg::DEBOUNCE_RESET;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int fail_count = 0;
    int result_count = 0;
    int hold_left = 0;
    int stall_cycles = 0;
    logic [recs_pkg::TIME_W-1:0] gen_time = '0;

    rotary_encoder_count_speed dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Works out what one accepted edge does to the count and the kept time.
    function automatic void track_edge(input edge_event_t ev);
        logic [recs_pkg::TIME_W-1:0] elapsed;
        logic [recs_pkg::TIME_W-1:0] quo;
        logic [recs_pkg::RATE_W-1:0] mag;
        step_result_t                res;
        elapsed = ev.stamp - kept_time;
        if (elapsed < {32'd0, debounce_shadow})
        begin
            kept_time = ev.stamp;
            return;
        end
        if (!ev.line_a)
            return;
        quo = recs_pkg::TIME_W'(recs_pkg::NS_PER_SEC)
              / ((elapsed == '0) ? recs_pkg::TIME_W'(1) : elapsed);
        if (quo == '0)
            quo = recs_pkg::TIME_W'(1);
        mag = quo[recs_pkg::RATE_W-1:0];
        if (ev.line_b)
        begin
            detent_count = detent_count + 1'b1;
            res.rate = mag;
        end
        else
        begin
            detent_count = detent_count - 1'b1;
            res.rate = -mag;
        end
        kept_time = ev.stamp;
        res.position = detent_count;
        step_q.push_back(res);
    endfunction

    function automatic logic [recs_pkg::TIME_W-1:0] extra_gap();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return recs_pkg::TIME_W'($urandom_range(0, 1000));
            2: return recs_pkg::TIME_W'($urandom);
            3: return {$urandom, $urandom} >> $urandom_range(16, 63);
            default: return recs_pkg::TIME_W'($urandom_range(0, 2000000000));
        endcase
    endfunction

    task automatic queue_event(input logic [recs_pkg::TIME_W-1:0] stamp, input logic a,
                               input logic b);
        edge_event_t ev;
        ev.stamp  = stamp;
        ev.line_a = a;
        ev.line_b = b;
        event_q.push_back(ev);
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (event_q.size() != 0 || s_axis_tvalid || step_q.size() != 0);
        // Bounced or ignored words may still be in flight inside the block.
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk)
    begin : drive_events
        edge_event_t taken;
        edge_event_t next_ev;
        logic        offer;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            cfg_valid     <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                debounce_shadow = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken.stamp  = s_axis_tdata[63:0];
                taken.line_a = s_axis_tdata[64];
                taken.line_b = s_axis_tdata[65];
                track_edge(taken);
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (debounce_q.size() != 0)
                begin
                    cfg_data  <= debounce_q.pop_front();
                    cfg_valid <= 1'b1;
                end
                else
                    cfg_valid <= 1'b0;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                offer = event_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct;
                if (offer)
                begin
                    next_ev = event_q.pop_front();
                    s_axis_tdata <= {6'd0, next_ev.line_b, next_ev.line_a, next_ev.stamp};
                end
                s_axis_tvalid <= offer;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        step_result_t got;
        step_result_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.position = m_axis_tdata[31:0];
                got.rate     = m_axis_tdata[62:32];
                result_count++;
                if (step_q.size() == 0)
                begin
                    $error("result word with nothing expected: position_out %0d signed_rate %0d",
                           $signed(got.position), $signed(got.rate));
                    fail_count++;
                end
                else
                begin
                    want = step_q.pop_front();
                    if (got.position !== want.position)
                    begin
                        $error("position_out: expected %0d, got %0d",
                               $signed(want.position), $signed(got.position));
                        fail_count++;
                    end
                    if (got.rate !== want.rate)
                    begin
                        $error("signed_rate: expected %0d, got %0d",
                               $signed(want.rate), $signed(got.rate));
                        fail_count++;
                    end
                end
                // Long back-pressure so the block fills up and stops taking edges.
                if (result_count == 40 || result_count == 900)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : run_test
        logic [recs_pkg::TIME_W-1:0] t;
        logic [recs_pkg::CFG_W-1:0]  db;
        logic                        a;
        logic                        b;
        int                          counted;
        int                          kind;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 33;
        recv_idle_pct = 79;
        db = recs_pkg::DEBOUNCE_RESET;
        // Bounce, exact threshold, ignored low line, both directions, rates at and
        // past one second, time wrapping through zero and running backward.
        t = recs_pkg::TIME_W'(db) - 1;
        queue_event(t, 1'b1, 1'b1);
        t = t + db;
        queue_event(t, 1'b1, 1'b1);
        queue_event(t + 5 * db, 1'b0, 1'b1);
        t = t + db + 1;
        queue_event(t, 1'b1, 1'b0);
        t = t + 3 * db;
        queue_event(t, 1'b1, 1'b0);
        t = t + 64'd1000000000;
        queue_event(t, 1'b1, 1'b1);
        t = t + 64'd1000000001;
        queue_event(t, 1'b1, 1'b0);
        t = t + 64'd999999999;
        queue_event(t, 1'b1, 1'b1);
        t = t + db - 1;
        queue_event(t, 1'b0, 1'b0);
        t = t + db;
        queue_event(t, 1'b1, 1'b1);
        queue_event({recs_pkg::TIME_W{1'b1}}, 1'b1, 1'b0);
        t = recs_pkg::TIME_W'(db) - 1;
        queue_event(t, 1'b1, 1'b0);
        t = t + db - 1;
        queue_event(t, 1'b0, 1'b0);
        t = t + db + 123456;
        queue_event(t, 1'b1, 1'b1);
        queue_event(64'h8000_0000_0000_0000, 1'b1, 1'b1);
        t = 64'h0000_0000_0000_1000;
        queue_event(t, 1'b1, 1'b0);
        gen_time = t;
        settle();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: db = 32'd1;
                1: db = 32'hFFFF_FFFF;
                2: db = $urandom_range(1, 5000);
                3: db = 32'd1000000;
                4: db = ($urandom == 0) ? 32'd1 : $urandom | 32'd1;
                default: db = 32'd1;
            endcase
            send_idle_pct = (phase < 2) ? 33 : (phase < 4) ? 79 : 0;
            recv_idle_pct = (phase < 2) ? 79 : (phase < 4) ? 33 : 0;
            debounce_q.push_back(db);
            do
                @(negedge clk);
            while (debounce_q.size() != 0 || cfg_valid);

            counted = 0;
            while (counted < PHASE_EDGES)
            begin
                kind = $urandom_range(0, 99);
                a = 1'b1;
                b = $urandom_range(0, 1);
                if (kind < 55)
                begin
                    t = gen_time + db + extra_gap();
                    gen_time = t;
                    counted++;
                end
                else if (kind < 75)
                begin
                    // Gap shorter than the debounce time, a quarter of them exactly one below it.
                    if ($urandom_range(0, 3) == 0)
                        t = gen_time + db - 1;
                    else
                        t = gen_time + $urandom_range(0, db - 1);
                    a = $urandom_range(0, 1);
                    gen_time = t;
                    counted++;
                end
                else if (kind < 87)
                begin
                    t = gen_time + db + extra_gap();
                    a = 1'b0;
                end
                else
                begin
                    t = {$urandom, $urandom};
                    a = $urandom_range(0, 1);
                    gen_time = t;
                    counted++;
                end
                queue_event(t, a, b);
            end
            settle();
        end

        if (fail_count == 0 && step_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
